// File: src/heq_pkg.sv
// Shared constants, types and helpers of the histogram equalizer.
package heq_pkg;

  localparam int unsigned LEVELS     = 256;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned LVL_W      = $clog2(LEVELS);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CUM_W      = COUNT_BITS + LVL_W;
  localparam int unsigned PROD_W     = CUM_W + PIX_W;
  localparam int unsigned REM_W      = COUNT_BITS + PIX_W;

  typedef logic [LVL_W-1:0]      addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [PIX_W-1:0]      pix_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  // Request bundle from the control logic to the bin memory.
  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    count_t wr_data;
    logic   clear;
  } bin_req_t;

  // Clamp a pixel to the highest level and to the table size.
  function automatic addr_t clamp_level(pix_t px, pix_t max_level);
    pix_t        p;
    logic [16:0] pe;
    begin
      p  = (px > max_level) ? max_level : px;
      pe = 17'(p);
      if (pe > 17'(LEVELS - 1)) pe = 17'(LEVELS - 1);
      clamp_level = LVL_W'(pe);
    end
  endfunction

endpackage

// File: src/heq_bins.sv
// Histogram bin memory with per-entry valid bits so a frame clear empties every entry at once.
module heq_bins (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  heq_pkg::bin_req_t req_i,
  output heq_pkg::count_t   rd_data_o
);
  import heq_pkg::*;

  count_t            mem [LEVELS];
  logic [LEVELS-1:0] valid_q;
  count_t            data_q;
  logic              vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) mem[req_i.wr_addr] <= req_i.wr_data;
    if (req_i.rd_en) data_q <= mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (req_i.rd_en) vld_q <= req_i.clear ? 1'b0 : valid_q[req_i.rd_addr];
      if (req_i.clear) valid_q <= '0;
      else if (req_i.wr_en) valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // An entry never written since the last clear reads as zero.
  assign rd_data_o = vld_q ? data_q : '0;

endmodule

// File: src/heq_lmap.sv
// Level mapping table memory with a registered read port.
module heq_lmap (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  heq_pkg::addr_t       wr_addr_i,
  input  heq_pkg::pix_t        wr_data_i,
  input  logic                 rd_en_i,
  input  heq_pkg::addr_t       rd_addr_i,
  output heq_pkg::pix_t        rd_data_o
);
  import heq_pkg::*;

  pix_t mem [LEVELS];
  pix_t data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = data_q;

endmodule

// File: src/heq_div.sv
// Iterative restoring divider giving an 8-bit quotient that saturates at all ones.
module heq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [heq_pkg::PROD_W-1:0]  num_i,
  input  heq_pkg::count_t             den_i,
  output logic                        done_o,
  output heq_pkg::pix_t               quo_o
);
  import heq_pkg::*;

  logic [REM_W-1:0] rem_q, dsh_q;
  pix_t             q_q;
  logic             ovf_q;
  logic [2:0]       step_q;
  logic             busy_q, done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= num_i >= PROD_W'({den_i, {PIX_W{1'b0}}});
      rem_q <= num_i[REM_W-1:0];
      dsh_q <= REM_W'({den_i, {(PIX_W-1){1'b0}}});
      q_q   <= '0;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        q_q   <= {q_q[PIX_W-2:0], 1'b1};
      end else begin
        q_q   <= {q_q[PIX_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == 3'(PIX_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'(PIX_W - 1)) busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = ovf_q ? {PIX_W{1'b1}} : q_q;

endmodule

// File: src/histogram_equalizer.sv
// Top level of the histogram equalizer: control sequencer, counters and output register.
//
// Count beats (op 0) add their clamped pixel to a histogram held in a bin
// memory; each count beat reads the bin and writes it back before the next
// beat is taken, so there is no overlap on the same entry. A new frame is
// started by the first count beat after map beats; it clears the whole
// histogram at once through per-bin valid bits. The count beat flagged last
// then builds the mapping table, one level at a time: read the bin, add it to
// the running sum, multiply by max_level, then divide by the pixel total in an
// eight-step shift-subtract divider. Levels above max_level are written with
// max_level directly, and in_stall_o stays high for the whole build. A map
// beat (op 1) reads the table and then loads the output register, waiting
// while a stalled result is held; the register holds a waiting result while
// the block takes the next beat.
module histogram_equalizer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wen_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [7:0]           pixel_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           level_o
);
  import heq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CNT  = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_BRD  = 3'd3;
  localparam logic [2:0] S_BACC = 3'd4;
  localparam logic [2:0] S_BMUL = 3'd5;
  localparam logic [2:0] S_BST  = 3'd6;
  localparam logic [2:0] S_BDIV = 3'd7;

  logic [2:0]        state_q, state_d;
  pix_t              max_q;
  count_t            total_q, total_d;
  logic              phase_q, phase_d;
  addr_t             addr_q, addr_d;
  logic              last_q, last_d;
  logic [CUM_W-1:0]  cum_q, cum_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              ovalid_q, ovalid_d;
  pix_t              level_q, level_d;

  bin_req_t          bin_req;
  count_t            bin_rd;
  logic              map_we, map_re;
  addr_t             map_wa, map_ra;
  pix_t              map_wd, map_rd;
  logic              div_start, div_done;
  pix_t              div_quo;
  logic              accept;
  addr_t             pix_c;
  logic              out_free;
  logic              end_level;

  heq_bins u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (bin_req),
    .rd_data_o (bin_rd)
  );

  heq_lmap u_lmap (
    .clk_i     (clk_i),
    .wr_en_i   (map_we),
    .wr_addr_i (map_wa),
    .wr_data_i (map_wd),
    .rd_en_i   (map_re),
    .rd_addr_i (map_ra),
    .rd_data_o (map_rd)
  );

  heq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (total_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pix_c      = clamp_level(pixel_i, max_q);
  assign out_free   = !ovalid_q || !out_stall_i;
  assign end_level  = (addr_q == LVL_W'(LEVELS - 1));

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    phase_d   = phase_q;
    addr_d    = addr_q;
    last_d    = last_q;
    cum_d     = cum_q;
    prod_d    = prod_q;
    ovalid_d  = ovalid_q && out_stall_i;
    level_d   = level_q;
    bin_req   = '0;
    map_we    = 1'b0;
    map_wa    = addr_q;
    map_wd    = '0;
    map_re    = 1'b0;
    map_ra    = pix_c;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i) begin
            map_re  = 1'b1;
            phase_d = 1'b1;
            state_d = S_MAP;
          end else begin
            // The first count beat after map beats opens a new frame.
            bin_req.clear   = phase_q;
            bin_req.rd_en   = 1'b1;
            bin_req.rd_addr = pix_c;
            phase_d         = 1'b0;
            if (phase_q) total_d = count_t'(1);
            else if (total_q != COUNT_MAX) total_d = total_q + count_t'(1);
            addr_d  = pix_c;
            last_d  = last_i;
            state_d = S_CNT;
          end
        end
      end
      S_CNT: begin
        bin_req.wr_en   = 1'b1;
        bin_req.wr_addr = addr_q;
        bin_req.wr_data = (bin_rd != COUNT_MAX) ? bin_rd + count_t'(1) : bin_rd;
        if (last_q) begin
          addr_d  = '0;
          cum_d   = '0;
          state_d = S_BRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MAP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          level_d  = map_rd;
          state_d  = S_IDLE;
        end
      end
      S_BRD: begin
        if (PIX_W'(addr_q) > max_q) begin
          // Levels above the top gray level map straight to it.
          map_we = 1'b1;
          map_wd = max_q;
          addr_d = addr_q + addr_t'(1);
          if (end_level) state_d = S_IDLE;
        end else begin
          bin_req.rd_en   = 1'b1;
          bin_req.rd_addr = addr_q;
          state_d         = S_BACC;
        end
      end
      S_BACC: begin
        cum_d   = cum_q + CUM_W'(bin_rd);
        state_d = S_BMUL;
      end
      S_BMUL: begin
        prod_d  = PROD_W'(cum_q) * PROD_W'(max_q);
        state_d = S_BST;
      end
      S_BST: begin
        if (total_q == '0) begin
          // With no pixels counted, every level up to max_level maps to zero.
          map_we = 1'b1;
          map_wd = '0;
          addr_d = addr_q + addr_t'(1);
          state_d = end_level ? S_IDLE : S_BRD;
        end else begin
          div_start = 1'b1;
          state_d   = S_BDIV;
        end
      end
      S_BDIV: begin
        if (div_done) begin
          map_we  = 1'b1;
          map_wd  = (div_quo > max_q) ? max_q : div_quo;
          addr_d  = addr_q + addr_t'(1);
          state_d = end_level ? S_IDLE : S_BRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      max_q    <= 8'd255;
      total_q  <= '0;
      phase_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
      if (cfg_wen_i) max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    last_q  <= last_d;
    cum_q   <= cum_d;
    prod_q  <= prod_d;
    level_q <= level_d;
  end

  assign out_valid_o = ovalid_q;
  assign level_o     = level_q;

endmodule
